@@ rtl/core/tlb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tlb_pkg;
    localparam logic [2:0] REQ_LOOKUP   = 3'd0;
    localparam logic [2:0] REQ_INS_L1   = 3'd1;
    localparam logic [2:0] REQ_INS_L2   = 3'd2;
    localparam logic [2:0] REQ_FLUSH_L1 = 3'd3;
    localparam logic [2:0] REQ_FLUSH_L2 = 3'd4;

    localparam logic [1:0] LVL_L1   = 2'd0;
    localparam logic [1:0] LVL_L2   = 2'd1;
    localparam logic [1:0] LVL_MISS = 2'd2;
    localparam logic [1:0] LVL_DONE = 2'd3;

    localparam int AGE_BITS = 8;
    localparam int CFG_BITS = 16;
    localparam logic CFG_L1 = 1'b0;
    localparam logic CFG_L2 = 1'b1;

    typedef struct packed {
        logic age_l1;
        logic search_l1;
        logic age_l2;
        logic search_l2;
        logic ins_l1;
        logic ins_l2;
        logic flush_l1;
        logic flush_l2;
        logic copy;
    } tlb_cmd_t;

    typedef struct packed {
        logic l1_hit;
        logic l2_hit;
    } tlb_stat_t;
endpackage
`default_nettype wire

@@ rtl/core/tlb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tlb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic [2:0]       req_type,
    input  wire logic             out_free,
    input  wire logic             l1_due,
    input  wire logic             l2_due,
    input  wire tlb_pkg::tlb_stat_t stat,
    output tlb_pkg::tlb_cmd_t     cmd,
    output logic                  busy,
    output logic                  done,
    output logic [1:0]            level
);
    import tlb_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_L1, S_L1CHK, S_L2, S_L2CHK, S_OUT} state_t;
    state_t state_reg, state_next;
    logic [1:0] level_reg, level_next;

    assign busy  = (state_reg != S_IDLE);
    assign level = level_reg;
    assign done  = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == REQ_LOOKUP)
                    begin
                        state_next = S_L1;
                    end
                    else
                    begin
                        level_next = LVL_DONE;
                        state_next = S_OUT;
                        cmd.ins_l1   = (req_type == REQ_INS_L1);
                        cmd.ins_l2   = (req_type == REQ_INS_L2);
                        cmd.flush_l1 = (req_type == REQ_FLUSH_L1);
                        cmd.flush_l2 = (req_type == REQ_FLUSH_L2);
                    end
                end
            end
            S_L1:
            begin
                cmd.age_l1 = l1_due;
                state_next = S_L1CHK;
            end
            S_L1CHK:
            begin
                cmd.search_l1 = 1'b1;
                if (stat.l1_hit)
                begin
                    level_next = LVL_L1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_L2;
                end
            end
            S_L2:
            begin
                cmd.age_l2 = l2_due;
                state_next = S_L2CHK;
            end
            S_L2CHK:
            begin
                cmd.search_l2 = 1'b1;
                cmd.copy = stat.l2_hit;
                level_next = stat.l2_hit ? LVL_L2 : LVL_MISS;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            level_reg <= LVL_DONE;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tlb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tlb_dp #(
    parameter int L1_ENTRIES = 16,
    parameter int L2_ENTRIES = 64,
    parameter int PAGE_BITS  = 22,
    parameter int FRAME_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_fire,
    input  wire logic [PAGE_BITS-1:0]  page_in,
    input  wire logic [FRAME_BITS-1:0] frame_in,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_idx,
    input  wire logic [tlb_pkg::CFG_BITS-1:0] cfg_data,
    input  wire tlb_pkg::tlb_cmd_t     cmd,
    output tlb_pkg::tlb_stat_t         stat,
    output logic                       l1_due,
    output logic                       l2_due,
    output logic                       cfg_busy,
    output logic [FRAME_BITS-1:0]      frame_out
);
    import tlb_pkg::*;

    localparam int L1W = (L1_ENTRIES > 1) ? $clog2(L1_ENTRIES) : 1;
    localparam int L2W = (L2_ENTRIES > 1) ? $clog2(L2_ENTRIES) : 1;
    localparam int L1P = 1 << L1W;
    localparam int L2P = 1 << L2W;
    localparam logic [4:0] REM_STEPS = 5'(CFG_BITS);

    logic [L1_ENTRIES-1:0] l1_valid_reg;
    logic [AGE_BITS-1:0]   l1_age_reg [L1_ENTRIES];
    logic [PAGE_BITS-1:0]  l1_tag_reg [L1_ENTRIES];
    logic [FRAME_BITS-1:0] l1_frame_reg [L1_ENTRIES];
    logic [L2_ENTRIES-1:0] l2_valid_reg;
    logic [AGE_BITS-1:0]   l2_age_reg [L2_ENTRIES];
    logic [PAGE_BITS-1:0]  l2_tag_reg [L2_ENTRIES];
    logic [FRAME_BITS-1:0] l2_frame_reg [L2_ENTRIES];

    logic [CFG_BITS-1:0] l1_per_reg, l2_per_reg, l1_cnt_reg, l2_cnt_reg;
    logic [CFG_BITS-1:0] l1_mod_reg, l2_mod_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] fout_reg;

    // Counter modulo the period is tracked incrementally, so no divider is needed.
    // When the 16-bit count wraps to zero the phase restarts at zero as well.
    logic [CFG_BITS-1:0] l1_mod_inc, l2_mod_inc;
    assign l1_mod_inc = (l1_cnt_reg == '1 || l1_mod_reg + 1'b1 == l1_per_reg) ? '0
                      : l1_mod_reg + 1'b1;
    assign l2_mod_inc = (l2_cnt_reg == '1 || l2_mod_reg + 1'b1 == l2_per_reg) ? '0
                      : l2_mod_reg + 1'b1;
    assign l1_due = (l1_per_reg != '0) && (l1_mod_inc == '0);
    assign l2_due = (l2_per_reg != '0) && (l2_mod_inc == '0);

    // After a period write, the phase (count modulo the new period) is found by a
    // restoring remainder that takes one count bit per cycle.
    logic [4:0]          l1_rstep_reg, l2_rstep_reg;
    logic [CFG_BITS-1:0] l1_rnum_reg, l2_rnum_reg, l1_rrem_reg, l2_rrem_reg;
    logic [CFG_BITS:0]   l1_rtrial, l2_rtrial;
    logic [CFG_BITS-1:0] l1_rrem_next, l2_rrem_next;
    assign l1_rtrial = {l1_rrem_reg, l1_rnum_reg[CFG_BITS-1]};
    assign l2_rtrial = {l2_rrem_reg, l2_rnum_reg[CFG_BITS-1]};
    assign l1_rrem_next = (l1_rtrial >= {1'b0, l1_per_reg})
                        ? CFG_BITS'(l1_rtrial - {1'b0, l1_per_reg}) : l1_rtrial[CFG_BITS-1:0];
    assign l2_rrem_next = (l2_rtrial >= {1'b0, l2_per_reg})
                        ? CFG_BITS'(l2_rtrial - {1'b0, l2_per_reg}) : l2_rtrial[CFG_BITS-1:0];
    assign cfg_busy = (l1_rstep_reg != '0) || (l2_rstep_reg != '0);

    // Priority match and victim selection.
    logic l1_hit, l2_hit, l1_inv, l2_inv;
    logic [L1W-1:0] l1_hidx, l1_vidx, l1_min;
    logic [L2W-1:0] l2_hidx, l2_vidx, l2_min;
    logic [AGE_BITS-1:0] l1_mage [L1P];
    logic [L1W-1:0]      l1_midx [L1P];
    logic [AGE_BITS-1:0] l2_mage [L2P];
    logic [L2W-1:0]      l2_midx [L2P];

    always_comb
    begin
        l1_hit = 1'b0; l1_hidx = '0; l1_inv = 1'b0; l1_vidx = '0;
        for (int i = L1_ENTRIES - 1; i >= 0; i--)
        begin
            if (l1_valid_reg[i] && l1_tag_reg[i] == page_reg)
            begin
                l1_hit = 1'b1; l1_hidx = L1W'(i);
            end
            if (!l1_valid_reg[i])
            begin
                l1_inv = 1'b1; l1_vidx = L1W'(i);
            end
        end
        // Minimum age by a comparison tree; on a tie the lower index wins.
        for (int i = 0; i < L1_ENTRIES; i++)
        begin
            l1_mage[i] = l1_age_reg[i];
            l1_midx[i] = L1W'(i);
        end
        for (int i = L1_ENTRIES; i < L1P; i++)
        begin
            l1_mage[i] = '1;
            l1_midx[i] = L1W'(i);
        end
        for (int s = 1; s < L1P; s = s * 2)
        begin
            for (int i = 0; i + s < L1P; i = i + 2 * s)
            begin
                if (l1_mage[i + s] < l1_mage[i])
                begin
                    l1_mage[i] = l1_mage[i + s];
                    l1_midx[i] = l1_midx[i + s];
                end
            end
        end
        l1_min = l1_midx[0];
        if (!l1_inv)
        begin
            l1_vidx = l1_min;
        end
        l2_hit = 1'b0; l2_hidx = '0; l2_inv = 1'b0; l2_vidx = '0;
        for (int i = L2_ENTRIES - 1; i >= 0; i--)
        begin
            if (l2_valid_reg[i] && l2_tag_reg[i] == page_reg)
            begin
                l2_hit = 1'b1; l2_hidx = L2W'(i);
            end
            if (!l2_valid_reg[i])
            begin
                l2_inv = 1'b1; l2_vidx = L2W'(i);
            end
        end
        for (int i = 0; i < L2_ENTRIES; i++)
        begin
            l2_mage[i] = l2_age_reg[i];
            l2_midx[i] = L2W'(i);
        end
        for (int i = L2_ENTRIES; i < L2P; i++)
        begin
            l2_mage[i] = '1;
            l2_midx[i] = L2W'(i);
        end
        for (int s = 1; s < L2P; s = s * 2)
        begin
            for (int i = 0; i + s < L2P; i = i + 2 * s)
            begin
                if (l2_mage[i + s] < l2_mage[i])
                begin
                    l2_mage[i] = l2_mage[i + s];
                    l2_midx[i] = l2_midx[i + s];
                end
            end
        end
        l2_min = l2_midx[0];
        if (!l2_inv)
        begin
            l2_vidx = l2_min;
        end
    end

    assign stat.l1_hit = l1_hit;
    assign stat.l2_hit = l2_hit;
    assign frame_out = fout_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            page_reg <= page_in;
        end
        if (cmd.ins_l1)
        begin
            l1_tag_reg[l1_vidx]   <= page_in;
            l1_frame_reg[l1_vidx] <= frame_in;
        end
        if (cmd.ins_l2)
        begin
            l2_tag_reg[l2_vidx]   <= page_in;
            l2_frame_reg[l2_vidx] <= frame_in;
        end
        if (cmd.copy)
        begin
            l1_tag_reg[l1_vidx]   <= l2_tag_reg[l2_hidx];
            l1_frame_reg[l1_vidx] <= l2_frame_reg[l2_hidx];
        end
        if (in_fire)
        begin
            fout_reg <= '0;
        end
        else if (cmd.search_l1 && l1_hit)
        begin
            fout_reg <= l1_frame_reg[l1_hidx];
        end
        else if (cmd.search_l2 && l2_hit)
        begin
            fout_reg <= l2_frame_reg[l2_hidx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= '0;
            l2_valid_reg <= '0;
            for (int i = 0; i < L1_ENTRIES; i++) l1_age_reg[i] <= '0;
            for (int i = 0; i < L2_ENTRIES; i++) l2_age_reg[i] <= '0;
            l1_per_reg <= CFG_BITS'(1);
            l2_per_reg <= CFG_BITS'(1);
            l1_cnt_reg <= '0;
            l2_cnt_reg <= '0;
            l1_mod_reg <= '0;
            l2_mod_reg <= '0;
            l1_rstep_reg <= '0;
            l2_rstep_reg <= '0;
            l1_rnum_reg <= '0;
            l2_rnum_reg <= '0;
            l1_rrem_reg <= '0;
            l2_rrem_reg <= '0;
        end
        else
        begin
            // A new period restarts the phase from the running count.
            if (cfg_we && cfg_idx == CFG_L1)
            begin
                l1_per_reg   <= cfg_data;
                l1_rstep_reg <= REM_STEPS;
                l1_rnum_reg  <= l1_cnt_reg;
                l1_rrem_reg  <= '0;
            end
            else if (l1_rstep_reg != '0)
            begin
                l1_rstep_reg <= l1_rstep_reg - 1'b1;
                l1_rnum_reg  <= {l1_rnum_reg[CFG_BITS-2:0], 1'b0};
                l1_rrem_reg  <= l1_rrem_next;
                if (l1_rstep_reg == 5'd1)
                begin
                    l1_mod_reg <= l1_rrem_next;
                end
            end
            if (cfg_we && cfg_idx == CFG_L2)
            begin
                l2_per_reg   <= cfg_data;
                l2_rstep_reg <= REM_STEPS;
                l2_rnum_reg  <= l2_cnt_reg;
                l2_rrem_reg  <= '0;
            end
            else if (l2_rstep_reg != '0)
            begin
                l2_rstep_reg <= l2_rstep_reg - 1'b1;
                l2_rnum_reg  <= {l2_rnum_reg[CFG_BITS-2:0], 1'b0};
                l2_rrem_reg  <= l2_rrem_next;
                if (l2_rstep_reg == 5'd1)
                begin
                    l2_mod_reg <= l2_rrem_next;
                end
            end
            if (cmd.age_l1)
            begin
                for (int i = 0; i < L1_ENTRIES; i++) l1_age_reg[i] <= l1_age_reg[i] >> 1;
            end
            if (cmd.age_l2)
            begin
                for (int i = 0; i < L2_ENTRIES; i++) l2_age_reg[i] <= l2_age_reg[i] >> 1;
            end
            if (cmd.search_l1)
            begin
                l1_cnt_reg <= l1_cnt_reg + 1'b1;
                l1_mod_reg <= (l1_per_reg == '0) ? '0 : l1_mod_inc;
                if (l1_hit)
                begin
                    l1_age_reg[l1_hidx][AGE_BITS-1] <= 1'b1;
                end
            end
            if (cmd.search_l2)
            begin
                l2_cnt_reg <= l2_cnt_reg + 1'b1;
                l2_mod_reg <= (l2_per_reg == '0) ? '0 : l2_mod_inc;
                if (l2_hit)
                begin
                    l2_age_reg[l2_hidx][AGE_BITS-1] <= 1'b1;
                end
            end
            if (cmd.copy)
            begin
                l1_valid_reg[l1_vidx] <= 1'b1;
                l1_age_reg[l1_vidx] <= {1'b1, l2_age_reg[l2_hidx][AGE_BITS-2:0]};
            end
            if (cmd.ins_l1)
            begin
                l1_valid_reg[l1_vidx] <= 1'b1;
                l1_age_reg[l1_vidx] <= '0;
            end
            if (cmd.ins_l2)
            begin
                l2_valid_reg[l2_vidx] <= 1'b1;
                l2_age_reg[l2_vidx] <= '0;
            end
            if (cmd.flush_l1)
            begin
                l1_valid_reg <= '0;
                for (int i = 0; i < L1_ENTRIES; i++) l1_age_reg[i] <= '0;
            end
            if (cmd.flush_l2)
            begin
                l2_valid_reg <= '0;
                for (int i = 0; i < L2_ENTRIES; i++) l2_age_reg[i] <= '0;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/two_level_tlb_aging_lru_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-level fully associative TLB with aging-counter replacement.
// Input channel s_axis carries a request word: req_type, page_number and
// frame_number. Output channel m_axis returns one word per request:
// hit_level and frame_out (zero on a miss or a non-lookup request).
// Inserts and flushes go from acceptance straight to the result step; a lookup
// walks an aging state and a search state for L1 and, on an L1 miss, for L2, and
// the copy of an L2 hit into L1 is issued together with the L2 search.
// No new word is accepted until the controller has returned to idle and any
// recompute of the aging phase after a configuration write has finished.
// One request is processed at a time. A new request may be accepted while the
// previous result still waits in the output register; it then holds at its
// result step, and s_axis_tready stays low until the receiver takes the word.
// Reset clears all valid bits, aging counters and search counts and sets
// both age periods to 1. Configuration writes on cfg_we/cfg_addr/cfg_wdata
// must be made while no request is in flight; s_axis_tready is low during the
// write cycle and while the aging phase is recomputed after it.
module two_level_tlb_aging_lru_top #(
    parameter int L1_ENTRIES = 16,
    parameter int L2_ENTRIES = 64,
    parameter int PAGE_BITS  = 22,
    parameter int FRAME_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // req_type[2:0], page_number, frame_number, zero pad
    input  wire logic [((3 + PAGE_BITS + FRAME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // hit_level[1:0], frame_out, zero pad
    output logic [((2 + FRAME_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  wire logic cfg_we,
    input  wire logic cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import tlb_pkg::*;

    localparam int OW = ((2 + FRAME_BITS + 7) / 8) * 8;

    tlb_cmd_t  cmd;
    tlb_stat_t stat;
    logic busy, done, l1_due, l2_due, in_fire, vld_reg, cfg_busy;
    logic [1:0] level;
    logic [FRAME_BITS-1:0] fout;

    assign s_axis_tready = !busy && !cfg_busy && !cfg_we;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    tlb_ctrl u_ctrl (
        .clk, .rst_n, .in_fire,
        .req_type(s_axis_tdata[2:0]),
        .out_free(!vld_reg || m_axis_tready),
        .l1_due, .l2_due, .stat, .cmd, .busy, .done, .level
    );

    tlb_dp #(.L1_ENTRIES(L1_ENTRIES), .L2_ENTRIES(L2_ENTRIES),
             .PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)) u_dp (
        .clk, .rst_n, .in_fire,
        .page_in(s_axis_tdata[3 +: PAGE_BITS]),
        .frame_in(s_axis_tdata[3 + PAGE_BITS +: FRAME_BITS]),
        .cfg_we, .cfg_idx(cfg_addr), .cfg_data(cfg_wdata),
        .cmd, .stat, .l1_due, .l2_due, .cfg_busy, .frame_out(fout)
    );

    logic [OW-1:0] data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            data_reg <= '0;
        end
        else
        begin
            if (done)
            begin
                vld_reg  <= 1'b1;
                data_reg <= OW'({fout, level});
            end
            else if (m_axis_tready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end
    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = data_reg;
endmodule
`default_nettype wire

@@ rtl/core/tlb_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tlb_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [1:0] lvl
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output word dropped");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(lvl)) else $error("output word changed");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accepted while busy");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid || !$past(m_axis_tvalid)
        || $past(m_axis_tvalid && !m_axis_tready)) else $error("result too early");
endmodule

bind two_level_tlb_aging_lru_top tlb_chk u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .lvl(m_axis_tdata[1:0])
);
`default_nettype wire
